@@ sv/mbss_pkg.sv @@
// Shared types and constants for the multi-block substring search unit.
// Holds the command codes, the stream field widths and the control bundle
// that drives the row of match cells. No dependencies.
package mbss_pkg;

  // Field widths of one transaction
  localparam int CMD_W     = 3;
  localparam int BYTE_W    = 8;
  localparam int BLOCK_W   = 8;
  localparam int POS_W     = 12;
  localparam int S_TDATA_W = 32;
  localparam int M_TDATA_W = 24;

  // Command codes carried on the input tuser
  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR_TEXT  = 3'd0,
    CMD_APPEND_TEXT = 3'd1,
    CMD_CLOSE_BLOCK = 3'd2,
    CMD_CLEAR_PAT   = 3'd3,
    CMD_APPEND_PAT  = 3'd4,
    CMD_SEARCH      = 3'd5
  } cmd_t;

  // Control broadcast to every match cell
  typedef struct packed {
    logic              pat_shift;   // shift a new pattern byte into the row
    logic              pat_clear;   // drop the whole pattern
    logic              match_clear; // restart partial matches at a block start
    logic              match_step;  // advance partial matches by one text byte
    logic [BYTE_W-1:0] text_byte;   // text byte under comparison
  } cell_ctl_t;

endpackage

@@ sv/mbss_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Used for the text store and the block end table. No dependencies.
module mbss_ram #(
  parameter int   WIDTH = 8,
  parameter int   DEPTH = 16,
  localparam int  AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ sv/mbss_cell.sv @@
// One match cell: holds one pattern byte, its in-use flag and one partial
// match bit that moves to the next cell down each text byte. Uses mbss_pkg.
module mbss_cell (
  input  logic                          clk,
  input  logic                          rst,
  input  mbss_pkg::cell_ctl_t           ctl,
  input  logic [mbss_pkg::BYTE_W-1:0]   pat_in,
  input  logic                          used_in,
  input  logic                          match_in,
  output logic [mbss_pkg::BYTE_W-1:0]   pat_out,
  output logic                          used_out,
  output logic                          match_out
);
  import mbss_pkg::*;

  logic [BYTE_W-1:0] pat;
  logic              used;
  logic              match;

  // Pattern byte moves up the row on each append
  always_ff @(posedge clk) begin
    if (ctl.pat_shift) begin
      pat <= pat_in;
    end
  end

  // In-use flag follows the pattern byte
  always_ff @(posedge clk) begin
    if (rst) begin
      used <= 1'b0;
    end else if (ctl.pat_clear) begin
      used <= 1'b0;
    end else if (ctl.pat_shift) begin
      used <= used_in;
    end
  end

  // Partial match: an unused cell always passes, a used one needs its byte
  always_ff @(posedge clk) begin
    if (rst) begin
      match <= 1'b0;
    end else if (ctl.match_clear) begin
      match <= !used;
    end else if (ctl.match_step) begin
      match <= !used || (match_in && (ctl.text_byte == pat));
    end
  end

  assign pat_out   = pat;
  assign used_out  = used;
  assign match_out = match;

endmodule

@@ sv/mbss_chain.sv @@
// Row of match cells. The newest pattern byte sits in cell 0, the first
// pattern byte in the highest used cell; a full match shows at cell 0.
// Uses mbss_pkg and mbss_cell.
module mbss_chain #(
  parameter int CELLS = 256
) (
  input  logic                        clk,
  input  logic                        rst,
  input  mbss_pkg::cell_ctl_t         ctl,
  input  logic [mbss_pkg::BYTE_W-1:0] pat_byte,
  output logic                        match
);
  import mbss_pkg::*;

  logic [BYTE_W-1:0] pat_q    [CELLS];
  logic [BYTE_W-1:0] pat_src  [CELLS];
  logic              used_q   [CELLS];
  logic              used_src [CELLS];
  logic              match_q  [CELLS];
  logic              match_src[CELLS];

  for (genvar k = 0; k < CELLS; k++) begin : g_cell
    // Pattern enters at cell 0; matches enter at the top, always passing
    if (k == 0) begin : g_first
      assign pat_src[k]  = pat_byte;
      assign used_src[k] = 1'b1;
    end else begin : g_inner
      assign pat_src[k]  = pat_q[k-1];
      assign used_src[k] = used_q[k-1];
    end
    if (k == CELLS - 1) begin : g_top
      assign match_src[k] = 1'b1;
    end else begin : g_below
      assign match_src[k] = match_q[k+1];
    end

    mbss_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctl      (ctl),
      .pat_in   (pat_src[k]),
      .used_in  (used_src[k]),
      .match_in (match_src[k]),
      .pat_out  (pat_q[k]),
      .used_out (used_q[k]),
      .match_out(match_q[k])
    );
  end

  assign match = match_q[0];

endmodule

@@ sv/multi_block_naive_substring_search_unit.sv @@
// Top level of the multi-block substring search unit: command decode, text
// and block stores, search sequencer and output register.
// Uses mbss_pkg, mbss_ram and mbss_chain.
//
//  channel | tvalid/tready      | tuser        | tdata (low bit first)
//  --------+--------------------+--------------+-------------------------------------
//  s_      | s_tvalid/s_tready  | command      | data_byte, start_block, start_pos
//  m_      | m_tvalid/m_tready  | found        | match_block, match_pos, overflow
//
// Load and clear commands are taken while idle. A search walks the blocks in
// order: it fetches the start block's begin offset (start block above 0), then
// per block fetches its end offset and, when scanned, reads one text byte per
// cycle from the start position, then drains the text RAM read and the cell row
// and moves on, unless a match ends the scan; finally it posts the result.
// rst is synchronous and clears all control state; stores keep their contents.
// s_tready is low while a search runs; a finished result waits in the output
// register while the next command is taken, and a second result waits for it.
module multi_block_naive_substring_search_unit #(
  parameter int TEXT_BYTES    = 4096,
  parameter int MAX_BLOCKS    = 256,
  parameter int PATTERN_BYTES = 256
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [mbss_pkg::S_TDATA_W-1:0] s_tdata,  // data_byte, start_block, start_pos, pad
  input  logic [mbss_pkg::CMD_W-1:0]     s_tuser,  // command
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [mbss_pkg::M_TDATA_W-1:0] m_tdata,  // match_block, match_pos, overflow, pad
  output logic                           m_tuser   // found
);
  import mbss_pkg::*;

  localparam int TAW = $clog2(TEXT_BYTES);
  localparam int FW  = $clog2(TEXT_BYTES + 1);
  localparam int BAW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CW  = $clog2(MAX_BLOCKS + 1);
  localparam int LW  = $clog2(PATTERN_BYTES + 1);
  localparam int SW  = (CW > BLOCK_W) ? CW : BLOCK_W;
  localparam int PW  = (FW > POS_W) ? FW : POS_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_BEG_REQ,
    S_BEG_WAIT,
    S_END_REQ,
    S_END_WAIT,
    S_SCAN,
    S_FINISH
  } state_t;

  state_t state;

  // Input transaction fields
  cmd_t               cmd;
  logic [BYTE_W-1:0]  in_byte;
  logic [BLOCK_W-1:0] in_block;
  logic [POS_W-1:0]   in_pos;
  logic               accept;

  assign cmd      = cmd_t'(s_tuser);
  assign in_byte  = s_tdata[BYTE_W-1:0];
  assign in_block = s_tdata[BYTE_W+BLOCK_W-1:BYTE_W];
  assign in_pos   = s_tdata[BYTE_W+BLOCK_W+POS_W-1:BYTE_W+BLOCK_W];
  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;

  // Load state
  logic [FW-1:0] text_fill;
  logic [CW-1:0] block_count;
  logic [LW-1:0] pat_len;
  logic          ovf;

  // Search state
  logic [CW-1:0]    x;
  logic             first;
  logic [POS_W-1:0] sp;
  logic [FW-1:0]    begin_off;
  logic [FW-1:0]    end_off;
  logic [FW-1:0]    addr;
  logic             v1;
  logic             v2;
  logic [FW-1:0]    j1;
  logic [FW-1:0]    j2;
  logic             hit;
  logic [POS_W-1:0] hit_pos;

  // Output register
  logic [BLOCK_W-1:0] res_block;
  logic [POS_W-1:0]   res_pos;
  logic               res_ovf;
  logic               res_found;

  // Store ports
  logic             text_we;
  logic             text_re;
  logic [BYTE_W-1:0] text_q;
  logic             blk_we;
  logic             blk_re;
  logic [BAW-1:0]   blk_raddr;
  logic [FW-1:0]    blk_q;

  // Cell row
  cell_ctl_t ctl;
  logic      row_match;

  // Derived search values
  logic             text_room;
  logic             block_room;
  logic             pat_room;
  logic             sb_ok;
  logic [CW-1:0]    x_inc;
  logic [CW-1:0]    x_dec;
  logic             x_last;
  logic [PW-1:0]    len_w;
  logic [PW-1:0]    i0_w;
  logic [POS_W-1:0] i0;
  logic [PW-1:0]    start_w;
  logic             issuing;
  logic             hit_now;
  logic [PW-1:0]    pos_w;
  logic [SW-1:0]    x_w;

  always_comb begin
    text_room  = text_fill < FW'(TEXT_BYTES);
    block_room = block_count < CW'(MAX_BLOCKS);
    pat_room   = pat_len < LW'(PATTERN_BYTES);
    sb_ok      = SW'(in_block) < SW'(block_count);
    x_inc      = x + CW'(1);
    x_dec      = x - CW'(1);
    x_last     = x_inc >= block_count;
    i0         = first ? sp : '0;
    len_w      = PW'(blk_q) - PW'(begin_off);
    i0_w       = PW'(i0);
    start_w    = PW'(begin_off) + i0_w;
    hit_now    = v2 && row_match;
    issuing    = (addr != end_off) && !hit_now;
    pos_w      = PW'(j2) + PW'(1'b1) - PW'(pat_len) - PW'(begin_off);
    x_w        = SW'(x);
  end

  // Store port control
  always_comb begin
    text_we   = accept && (cmd == CMD_APPEND_TEXT) && text_room;
    blk_we    = accept && (cmd == CMD_CLOSE_BLOCK) && block_room;
    text_re   = (state == S_SCAN) && issuing;
    blk_re    = (state == S_BEG_REQ) || (state == S_END_REQ);
    blk_raddr = (state == S_BEG_REQ) ? x_dec[BAW-1:0] : x[BAW-1:0];
  end

  // Cell row control
  always_comb begin
    ctl.pat_shift   = accept && (cmd == CMD_APPEND_PAT) && pat_room;
    ctl.pat_clear   = accept && (cmd == CMD_CLEAR_PAT);
    ctl.match_clear = (state == S_END_WAIT);
    ctl.match_step  = (state == S_SCAN) && v1;
    ctl.text_byte   = text_q;
  end

  mbss_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(TEXT_BYTES)
  ) u_text_ram (
    .clk  (clk),
    .we   (text_we),
    .waddr(text_fill[TAW-1:0]),
    .wdata(in_byte),
    .re   (text_re),
    .raddr(addr[TAW-1:0]),
    .rdata(text_q)
  );

  mbss_ram #(
    .WIDTH(FW),
    .DEPTH(MAX_BLOCKS)
  ) u_block_ram (
    .clk  (clk),
    .we   (blk_we),
    .waddr(block_count[BAW-1:0]),
    .wdata(text_fill),
    .re   (blk_re),
    .raddr(blk_raddr),
    .rdata(blk_q)
  );

  mbss_chain #(
    .CELLS(PATTERN_BYTES)
  ) u_chain (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .pat_byte(in_byte),
    .match   (row_match)
  );

  // Command decode, search sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      text_fill   <= '0;
      block_count <= '0;
      pat_len     <= '0;
      ovf         <= 1'b0;
      v1          <= 1'b0;
      v2          <= 1'b0;
      hit         <= 1'b0;
      m_tvalid    <= 1'b0;
    end else begin
      // Release the output register once its transaction completes,
      // unless a finished search refills it in the same cycle
      if (m_tvalid && m_tready && (state != S_FINISH)) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            case (cmd)
              CMD_CLEAR_TEXT: begin
                text_fill   <= '0;
                block_count <= '0;
                ovf         <= 1'b0;
              end
              CMD_APPEND_TEXT: begin
                if (text_room) text_fill <= text_fill + FW'(1);
                else           ovf       <= 1'b1;
              end
              CMD_CLOSE_BLOCK: begin
                if (block_room) block_count <= block_count + CW'(1);
                else            ovf         <= 1'b1;
              end
              CMD_CLEAR_PAT: begin
                pat_len <= '0;
                ovf     <= 1'b0;
              end
              CMD_APPEND_PAT: begin
                if (pat_room) pat_len <= pat_len + LW'(1);
                else          ovf     <= 1'b1;
              end
              CMD_SEARCH: begin
                x         <= CW'(in_block);
                sp        <= in_pos;
                first     <= 1'b1;
                hit       <= 1'b0;
                hit_pos   <= '0;
                begin_off <= '0;
                if (!sb_ok) begin
                  state <= S_FINISH;
                end else if (in_block == '0) begin
                  state <= S_END_REQ;
                end else begin
                  state <= S_BEG_REQ;
                end
              end
              default: begin
              end
            endcase
          end
        end

        S_BEG_REQ: begin
          state <= S_BEG_WAIT;
        end

        S_BEG_WAIT: begin
          begin_off <= blk_q;
          state     <= S_END_REQ;
        end

        S_END_REQ: begin
          state <= S_END_WAIT;
        end

        S_END_WAIT: begin
          end_off <= blk_q;
          if ((pat_len == '0) && (i0_w <= len_w)) begin
            // Empty pattern matches at the first valid position
            hit     <= 1'b1;
            hit_pos <= i0;
            state   <= S_FINISH;
          end else if ((pat_len != '0) && (i0_w < len_w)) begin
            addr  <= FW'(start_w);
            state <= S_SCAN;
          end else begin
            // Nothing to scan in this block: advance
            begin_off <= blk_q;
            x         <= x_inc;
            first     <= 1'b0;
            state     <= x_last ? S_FINISH : S_END_REQ;
          end
        end

        S_SCAN: begin
          if (hit_now) begin
            hit     <= 1'b1;
            hit_pos <= pos_w[POS_W-1:0];
            v1      <= 1'b0;
            v2      <= 1'b0;
            state   <= S_FINISH;
          end else if (!issuing && !v1 && !v2) begin
            // Block drained without a match: advance
            begin_off <= end_off;
            x         <= x_inc;
            first     <= 1'b0;
            state     <= x_last ? S_FINISH : S_END_REQ;
          end else begin
            if (issuing) addr <= addr + FW'(1);
            v1 <= issuing;
            j1 <= addr;
            v2 <= v1;
            j2 <= j1;
          end
        end

        S_FINISH: begin
          // Post the result once the output register is free
          if (!m_tvalid || m_tready) begin
            m_tvalid  <= 1'b1;
            res_found <= hit;
            res_block <= hit ? x_w[BLOCK_W-1:0] : '0;
            res_pos   <= hit ? hit_pos : '0;
            res_ovf   <= ovf;
            state     <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign m_tdata = {3'b000, res_ovf, res_pos, res_block};
  assign m_tuser = res_found;

endmodule

@@ verif/tb_multi_block_naive_substring_search_unit.sv @@
// Self-checking testbench for multi_block_naive_substring_search_unit.
// Drives text, pattern and search commands on the input stream and checks each result
// against a scoreboard that models the stores. Depends on mbss_pkg and the unit's RTL.
module tb_multi_block_naive_substring_search_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import mbss_pkg::*;

  localparam int TEXT_BYTES    = 4096;
  localparam int MAX_BLOCKS    = 256;
  localparam int PATTERN_BYTES = 256;
  localparam int STALL_LIMIT   = 50000;
  localparam int HOLD_CYCLES   = 300;
  localparam int DRAIN_CYCLES  = 20;
  localparam int PRINT_LIMIT   = 40;

  // Command codes the unit ignores
  localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

  // One search outcome
  typedef struct packed {
    logic               found;
    logic [BLOCK_W-1:0] blk;
    logic [POS_W-1:0]   pos;
    logic               ovf;
  } match_rsp_t;

  // Shadow of the text, block and pattern stores plus the queue of pending search outcomes
  class search_scoreboard;
    logic [BYTE_W-1:0] text_mem [TEXT_BYTES];
    logic [12:0]       block_end [MAX_BLOCKS];
    logic [BYTE_W-1:0] pat_mem [PATTERN_BYTES];
    int unsigned       n_blocks;
    int unsigned       fill;
    int unsigned       pat_len;
    bit                ovf;
    match_rsp_t        pending_matches[$];
    int                mismatches;

    function new();
      n_blocks   = 0;
      fill       = 0;
      pat_len    = 0;
      ovf        = 1'b0;
      mismatches = 0;
    endfunction

    function bit window_ok(int unsigned at);
      for (int unsigned k = 0; k < pat_len; k++) begin
        if (text_mem[at + k] !== pat_mem[k]) return 1'b0;
      end
      return 1'b1;
    endfunction

    // Scan closed blocks from the start block; later blocks start at offset 0
    function match_rsp_t predict_search(int unsigned sb, int unsigned sp);
      match_rsp_t  r;
      int unsigned x;
      int unsigned bgn;
      int unsigned len;
      int unsigned j;
      r     = '0;
      r.ovf = ovf;
      x     = sb;
      while (x < n_blocks && !r.found) begin
        bgn = (x == 0) ? 0 : block_end[x - 1];
        len = block_end[x] - bgn;
        if (len >= pat_len) begin
          j = (x == sb) ? sp : 0;
          while (j <= len - pat_len && !r.found) begin
            if (window_ok(bgn + j)) begin
              r.found = 1'b1;
              r.blk   = x[BLOCK_W-1:0];
              r.pos   = j[POS_W-1:0];
            end
            j++;
          end
        end
        x++;
      end
      return r;
    endfunction

    // Update the shadow stores for one accepted command transaction
    function void note_command(logic [CMD_W-1:0] cmd, logic [BYTE_W-1:0] b,
                               logic [BLOCK_W-1:0] sb, logic [POS_W-1:0] sp);
      case (cmd)
        CMD_CLEAR_TEXT: begin
          n_blocks = 0;
          fill     = 0;
          ovf      = 1'b0;
        end
        CMD_APPEND_TEXT: begin
          if (fill < TEXT_BYTES) begin
            text_mem[fill] = b;
            fill++;
          end else begin
            ovf = 1'b1;
          end
        end
        CMD_CLOSE_BLOCK: begin
          if (n_blocks < MAX_BLOCKS) begin
            block_end[n_blocks] = fill[12:0];
            n_blocks++;
          end else begin
            ovf = 1'b1;
          end
        end
        CMD_CLEAR_PAT: begin
          pat_len = 0;
          ovf     = 1'b0;
        end
        CMD_APPEND_PAT: begin
          if (pat_len < PATTERN_BYTES) begin
            pat_mem[pat_len] = b;
            pat_len++;
          end else begin
            ovf = 1'b1;
          end
        end
        CMD_SEARCH: pending_matches = {pending_matches, predict_search(sb, sp)};
        default: ;
      endcase
    endfunction

    task report_mismatch(string what);
      if (mismatches < PRINT_LIMIT) $display("[%0t] mismatch: %s", $realtime, what);
      mismatches++;
    endtask

    // Compare one accepted result transaction with the oldest pending outcome
    task check_result(match_rsp_t got);
      match_rsp_t want;
      if (pending_matches.size() == 0) begin
        report_mismatch("result transaction with no search pending");
      end else begin
        want = pending_matches.pop_front();
        if (got.found !== want.found)
          report_mismatch($sformatf("found got %0b want %0b", got.found, want.found));
        if (got.blk !== want.blk)
          report_mismatch($sformatf("match_block got %0d want %0d", got.blk, want.blk));
        if (got.pos !== want.pos)
          report_mismatch($sformatf("match_pos got %0d want %0d", got.pos, want.pos));
        if (got.ovf !== want.ovf)
          report_mismatch($sformatf("overflow got %0b want %0b", got.ovf, want.ovf));
      end
    endtask
  endclass

  logic                 clk      = 1'b0;
  logic                 rst      = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata  = '0;
  logic [CMD_W-1:0]     s_tuser  = CMD_CLEAR_TEXT;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;
  logic                 m_tuser;

  search_scoreboard search_sb = new();
  int src_idle_pct   = 0;
  int sink_stall_pct = 0;
  int items_sent     = 0;
  int stall_cycles   = 0;
  bit hold_req       = 1'b0;
  int hold_left      = 0;

  multi_block_naive_substring_search_unit DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #1 clk = ~clk;

  // Sink: random stalls, or a long hold-off when requested
  always @(posedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // Monitor both channels at each edge
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready)
        search_sb.note_command(s_tuser, s_tdata[7:0], s_tdata[15:8], s_tdata[27:16]);
      if (m_tvalid && m_tready)
        search_sb.check_result({m_tuser, m_tdata[7:0], m_tdata[19:8], m_tdata[20]});
    end
  end

  // Watchdog: end the run when no transaction moves for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("tb_multi_block_naive_substring_search_unit: FAIL");
      $finish;
    end
  end

  // Offer one command transaction and hold it until accepted
  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [BYTE_W-1:0] b,
                           input logic [BLOCK_W-1:0] blk, input logic [POS_W-1:0] pos);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {4'b0, pos, blk, b};
    do @(posedge clk); while (!s_tready);
    if (cmd <= CMD_SEARCH) items_sent++;
  endtask

  // Stop offering and wait until every pending search has answered
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (search_sb.pending_matches.size() != 0) @(posedge clk);
  endtask

  // Random field values at their exact widths
  function automatic logic [BYTE_W-1:0] rand_byte();
    return BYTE_W'($urandom);
  endfunction

  function automatic logic [BLOCK_W-1:0] rand_block();
    return BLOCK_W'($urandom);
  endfunction

  function automatic logic [POS_W-1:0] rand_pos();
    return POS_W'($urandom);
  endfunction

  // Mostly a two-letter alphabet so that short patterns hit often
  function automatic logic [BYTE_W-1:0] pick_byte();
    if ($urandom_range(9) < 7) return 8'h61 + BYTE_W'($urandom_range(1));
    return BYTE_W'($urandom);
  endfunction

  task automatic run_directed();
    // No blocks closed yet
    send_item(CMD_SEARCH, 8'h00, 8'h00, 12'h000);
    // Blocks: {00 FF 'a' 'b'}, empty, {'a' 'b' 'a'}, then an open block 'x'
    send_item(CMD_APPEND_TEXT, 8'h00, 8'hFF, 12'hFFF);
    send_item(CMD_APPEND_TEXT, 8'hFF, 8'h00, 12'h000);
    send_item(CMD_APPEND_TEXT, 8'h61, 8'h00, 12'h000);
    send_item(CMD_APPEND_TEXT, 8'h62, 8'h00, 12'h000);
    send_item(CMD_CLOSE_BLOCK, 8'hFF, 8'hFF, 12'hFFF);
    send_item(CMD_CLOSE_BLOCK, 8'h00, 8'h00, 12'h000);
    send_item(CMD_APPEND_TEXT, 8'h61, 8'h00, 12'h000);
    send_item(CMD_APPEND_TEXT, 8'h62, 8'h00, 12'h000);
    send_item(CMD_APPEND_TEXT, 8'h61, 8'h00, 12'h000);
    send_item(CMD_CLOSE_BLOCK, 8'h00, 8'h00, 12'h000);
    send_item(CMD_APPEND_TEXT, 8'h78, 8'h00, 12'h000);
    // Empty pattern: first valid position, past-end start skips to the next block
    send_item(CMD_SEARCH, 8'hFF, 8'h00, 12'h000);
    send_item(CMD_SEARCH, 8'h00, 8'h01, 12'h000);
    send_item(CMD_SEARCH, 8'h00, 8'h00, 12'hFFF);
    // Pattern "ab"
    send_item(CMD_APPEND_PAT, 8'h61, 8'h00, 12'h000);
    send_item(CMD_APPEND_PAT, 8'h62, 8'h00, 12'h000);
    send_item(CMD_SEARCH, 8'h00, 8'h00, 12'h000);
    send_item(CMD_SEARCH, 8'h00, 8'h00, 12'h003);
    send_item(CMD_SEARCH, 8'h00, 8'h02, 12'h001);
    send_item(CMD_SEARCH, 8'h00, 8'h03, 12'h000);
    send_item(CMD_SEARCH, 8'h00, 8'hFF, 12'hFFF);
    // Unused codes change nothing
    send_item(CMD_SPARE_6, 8'hFF, 8'hFF, 12'hFFF);
    send_item(CMD_SPARE_7, 8'hFF, 8'h00, 12'h000);
    // Pattern of extreme byte values
    send_item(CMD_CLEAR_PAT, 8'h00, 8'h00, 12'h000);
    send_item(CMD_APPEND_PAT, 8'h00, 8'h00, 12'h000);
    send_item(CMD_APPEND_PAT, 8'hFF, 8'h00, 12'h000);
    send_item(CMD_SEARCH, 8'h00, 8'h00, 12'h000);
  endtask

  // Fill the block table and the pattern store to capacity, then overrun each
  task automatic run_capacity();
    int i;
    send_item(CMD_CLEAR_TEXT, rand_byte(), rand_block(), rand_pos());
    send_item(CMD_CLEAR_PAT, rand_byte(), rand_block(), rand_pos());
    // Mostly empty blocks, one text byte in every sixteenth
    for (i = 0; i < MAX_BLOCKS; i++) begin
      if (i % 16 == 15) send_item(CMD_APPEND_TEXT, pick_byte(), rand_block(), rand_pos());
      send_item(CMD_CLOSE_BLOCK, rand_byte(), rand_block(), rand_pos());
    end
    // Pattern from the last stored byte
    send_item(CMD_APPEND_PAT, search_sb.text_mem[search_sb.fill - 1], rand_block(),
              rand_pos());
    send_item(CMD_SEARCH, rand_byte(), 8'h00, 12'h000);
    send_item(CMD_SEARCH, rand_byte(), 8'hFF, 12'h000);
    // Block table full: drop and flag
    send_item(CMD_CLOSE_BLOCK, rand_byte(), rand_block(), rand_pos());
    send_item(CMD_SEARCH, rand_byte(), 8'h00, 12'h000);
    // Empty pattern around the end of the last block
    send_item(CMD_CLEAR_PAT, rand_byte(), rand_block(), rand_pos());
    send_item(CMD_SEARCH, rand_byte(), 8'hFF, 12'hFFF);
    send_item(CMD_SEARCH, rand_byte(), 8'hFF, 12'h001);
    // Pattern store full
    for (i = 0; i <= PATTERN_BYTES; i++)
      send_item(CMD_APPEND_PAT, rand_byte(), rand_block(), rand_pos());
    send_item(CMD_SEARCH, rand_byte(), 8'd250, 12'h000);
    send_item(CMD_CLEAR_TEXT, rand_byte(), rand_block(), rand_pos());
    send_item(CMD_SEARCH, rand_byte(), 8'h00, 12'h000);
  endtask

  // Well-formed text and pattern loads with searches, plus stray and ignored commands
  task automatic run_random(int goal);
    int stop_at;
    int r;
    int nb;
    int len;
    int i;
    int k;
    stop_at = items_sent + goal;
    while (items_sent < stop_at) begin
      r = $urandom_range(99);
      if (r < 12) begin
        send_item(CMD_CLEAR_TEXT, rand_byte(), rand_block(), rand_pos());
        nb = $urandom_range(0, 6);
        for (i = 0; i < nb; i++) begin
          len = ($urandom_range(9) == 0) ? $urandom_range(20, 50) : $urandom_range(0, 8);
          for (k = 0; k < len; k++)
            send_item(CMD_APPEND_TEXT, pick_byte(), rand_block(), rand_pos());
          send_item(CMD_CLOSE_BLOCK, rand_byte(), rand_block(), rand_pos());
        end
        // Leave a few bytes in an open block
        len = $urandom_range(0, 3);
        for (k = 0; k < len; k++)
          send_item(CMD_APPEND_TEXT, pick_byte(), rand_block(), rand_pos());
      end else if (r < 27) begin
        send_item(CMD_CLEAR_PAT, rand_byte(), rand_block(), rand_pos());
        len = ($urandom_range(9) == 0) ? $urandom_range(4, 12) : $urandom_range(0, 3);
        for (k = 0; k < len; k++)
          send_item(CMD_APPEND_PAT, pick_byte(), rand_block(), rand_pos());
      end else if (r < 85) begin
        send_item(CMD_SEARCH, rand_byte(),
                  BLOCK_W'(($urandom_range(9) == 0) ? $urandom_range(255)
                                                    : $urandom_range(0, search_sb.n_blocks)),
                  POS_W'(($urandom_range(9) == 0) ? $urandom_range(4095)
                                                  : $urandom_range(0, 6)));
      end else if (r < 92) begin
        send_item($urandom_range(1) ? CMD_SPARE_6 : CMD_SPARE_7, rand_byte(), rand_block(),
                  rand_pos());
      end else begin
        send_item(CMD_W'($urandom_range(CMD_CLEAR_TEXT, CMD_SEARCH)), pick_byte(),
                  rand_block(), rand_pos());
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    run_directed();
    run_capacity();
    wait_drained();

    // No idling; hold the sink off while searches keep coming
    run_random(50);
    hold_req = 1'b1;
    repeat (8) send_item(CMD_SEARCH, rand_byte(), BLOCK_W'($urandom_range(0, 3)),
                         POS_W'($urandom_range(0, 4)));
    run_random(50);
    wait_drained();

    src_idle_pct = 66;
    run_random(60);
    wait_drained();

    src_idle_pct   = 0;
    sink_stall_pct = 66;
    run_random(60);
    wait_drained();

    src_idle_pct   = 18;
    sink_stall_pct = 18;
    run_random(60);
    wait_drained();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (search_sb.mismatches == 0 && search_sb.pending_matches.size() == 0) begin
      $display("tb_multi_block_naive_substring_search_unit: PASS");
    end else begin
      $display("tb_multi_block_naive_substring_search_unit: FAIL");
    end
    $finish;
  end

endmodule
